FILE: hdl/scat_pkg.sv
// Shared types, constants and keymap table for the scan code translator.
`default_nettype none
package scat_pkg;

   localparam int SCAN_WIDTH   = 8;
   localparam int KEY_WIDTH    = 7;
   localparam int CHAR_WIDTH   = 8;
   localparam int ROW_WIDTH    = 2 * CHAR_WIDTH;
   localparam int KEYMAP_DEPTH = 1 << KEY_WIDTH;

   localparam logic [KEY_WIDTH-1:0] KEY_LSHIFT = 7'd42;
   localparam logic [KEY_WIDTH-1:0] KEY_RSHIFT = 7'd54;
   localparam logic [KEY_WIDTH-1:0] KEY_CTRL   = 7'd29;
   localparam logic [KEY_WIDTH-1:0] KEY_META   = 7'd56;

   localparam logic [CHAR_WIDTH-1:0] CTRL_OFFSET = 8'h40;
   localparam logic [CHAR_WIDTH-1:0] META_BIT    = 8'h80;

   typedef enum logic [1:0] {
      KIND_PLAIN,
      KIND_SHIFT,
      KIND_CTRL,
      KIND_META
   } key_kind_type;

   typedef struct packed {
      logic                  release_key;
      key_kind_type          kind;
      logic                  shift_held;
      logic                  ctrl_held;
      logic                  meta_held;
   } stage_info_type;

   typedef struct packed {
      logic                  wr_en;
      logic [KEY_WIDTH-1:0]  wr_addr;
      logic [ROW_WIDTH-1:0]  wr_data;
      logic                  done;
   } fill_port_type;

   function automatic key_kind_type key_kind(input logic [KEY_WIDTH-1:0] key);
      key_kind_type kind;
      if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
         kind = KIND_SHIFT;
      end else if (key == KEY_CTRL) begin
         kind = KIND_CTRL;
      end else if (key == KEY_META) begin
         kind = KIND_META;
      end else begin
         kind = KIND_PLAIN;
      end
      return kind;
   endfunction

   // Row layout: shifted column in the upper byte, unshifted in the lower.
   function automatic logic [ROW_WIDTH-1:0] keymap_row(input logic [KEY_WIDTH-1:0] key);
      logic [ROW_WIDTH-1:0] row;
      case (key)
         7'd1:    row = {8'h1B, 8'h1B};
         7'd2:    row = {8'h21, 8'h31};
         7'd3:    row = {8'h40, 8'h32};
         7'd4:    row = {8'h23, 8'h33};
         7'd5:    row = {8'h24, 8'h34};
         7'd6:    row = {8'h25, 8'h35};
         7'd7:    row = {8'h5E, 8'h36};
         7'd8:    row = {8'h26, 8'h37};
         7'd9:    row = {8'h2A, 8'h38};
         7'd10:   row = {8'h28, 8'h39};
         7'd11:   row = {8'h29, 8'h30};
         7'd12:   row = {8'h5F, 8'h2D};
         7'd13:   row = {8'h2B, 8'h3D};
         7'd14:   row = {8'h08, 8'h08};
         7'd15:   row = {8'h09, 8'h09};
         7'd16:   row = {8'h51, 8'h71};
         7'd17:   row = {8'h57, 8'h77};
         7'd18:   row = {8'h45, 8'h65};
         7'd19:   row = {8'h52, 8'h72};
         7'd20:   row = {8'h54, 8'h74};
         7'd21:   row = {8'h59, 8'h79};
         7'd22:   row = {8'h55, 8'h75};
         7'd23:   row = {8'h49, 8'h69};
         7'd24:   row = {8'h4F, 8'h6F};
         7'd25:   row = {8'h50, 8'h70};
         7'd26:   row = {8'h7B, 8'h5B};
         7'd27:   row = {8'h7D, 8'h5D};
         7'd28:   row = {8'h0D, 8'h0D};
         7'd30:   row = {8'h41, 8'h61};
         7'd31:   row = {8'h53, 8'h73};
         7'd32:   row = {8'h44, 8'h64};
         7'd33:   row = {8'h46, 8'h66};
         7'd34:   row = {8'h47, 8'h67};
         7'd35:   row = {8'h48, 8'h68};
         7'd36:   row = {8'h4A, 8'h6A};
         7'd37:   row = {8'h4B, 8'h6B};
         7'd38:   row = {8'h4C, 8'h6C};
         7'd39:   row = {8'h3A, 8'h3B};
         7'd40:   row = {8'h22, 8'h27};
         7'd41:   row = {8'h7E, 8'h60};
         7'd43:   row = {8'h7C, 8'h5C};
         7'd44:   row = {8'h5A, 8'h7A};
         7'd45:   row = {8'h58, 8'h78};
         7'd46:   row = {8'h43, 8'h63};
         7'd47:   row = {8'h56, 8'h76};
         7'd48:   row = {8'h42, 8'h62};
         7'd49:   row = {8'h4E, 8'h6E};
         7'd50:   row = {8'h4D, 8'h6D};
         7'd51:   row = {8'h3C, 8'h2C};
         7'd52:   row = {8'h3E, 8'h2E};
         7'd53:   row = {8'h3F, 8'h2F};
         7'd57:   row = {8'h20, 8'h20};
         7'd71:   row = {8'h4A, 8'h4A};
         7'd72:   row = {8'h52, 8'h52};
         7'd73:   row = {8'h4B, 8'h4B};
         7'd74:   row = {8'h2D, 8'h2D};
         7'd75:   row = {8'h50, 8'h50};
         7'd76:   row = {8'h35, 8'h35};
         7'd77:   row = {8'h4F, 8'h4F};
         7'd78:   row = {8'h2B, 8'h2B};
         7'd79:   row = {8'h4D, 8'h4D};
         7'd80:   row = {8'h51, 8'h51};
         7'd81:   row = {8'h4E, 8'h4E};
         7'd82:   row = {8'h49, 8'h49};
         7'd83:   row = {8'h4C, 8'h4C};
         7'd84:   row = {8'h7E, 8'h7E};
         7'd86:   row = {8'h69, 8'h69};
         7'd87:   row = {8'h0C, 8'h0C};
         7'd88:   row = {8'h0D, 8'h0D};
         default: row = '0;
      endcase
      return row;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/scat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module scat_ram #(
   parameter int DATA_WIDTH = 16,
   parameter int DEPTH      = 128,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic                  rd_en,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output      logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hdl/scat_fill.sv
// Post-reset sweep that loads the keymap table into the keymap RAM.
`default_nettype none
module scat_fill (
   input  wire logic                    clock,
   input  wire logic                    reset,
   output      scat_pkg::fill_port_type fill
);
   import scat_pkg::*;

   logic [KEY_WIDTH:0] count_ff;
   logic [KEY_WIDTH:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (!count_ff[KEY_WIDTH]) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      fill.done    = count_ff[KEY_WIDTH];
      fill.wr_en   = !count_ff[KEY_WIDTH];
      fill.wr_addr = count_ff[KEY_WIDTH-1:0];
      fill.wr_data = keymap_row(count_ff[KEY_WIDTH-1:0]);
   end

endmodule
`default_nettype wire

FILE: hdl/scat_format.sv
// Character formation from a keymap row and the modifier snapshot.
`default_nettype none
module scat_format (
   input  wire logic [scat_pkg::ROW_WIDTH-1:0]  row,
   input  wire scat_pkg::stage_info_type        info,
   output      logic                            char_valid,
   output      logic [scat_pkg::CHAR_WIDTH-1:0] char_code
);
   import scat_pkg::*;

   logic [CHAR_WIDTH-1:0] shifted;
   logic [CHAR_WIDTH-1:0] entry;
   logic [CHAR_WIDTH-1:0] base;

   always_comb begin
      shifted    = row[ROW_WIDTH-1:CHAR_WIDTH];
      entry      = info.shift_held ? shifted : row[CHAR_WIDTH-1:0];
      base       = info.ctrl_held ? (shifted - CTRL_OFFSET) : entry;
      char_valid = 1'b0;
      char_code  = '0;
      if (!info.release_key && info.kind == KIND_PLAIN && entry != '0) begin
         char_valid = 1'b1;
         char_code  = info.meta_held ? (base | META_BIT) : base;
      end
   end

endmodule
`default_nettype wire

FILE: hdl/scancode_to_ascii_translator_core.sv
// Scan code set 1 to ASCII translator: modifier tracking, keymap RAM, output word.
//
// Usage:
//   req channel carries one scan code byte per word; bit 7 marks a release.
//   rsp channel returns exactly one word per request: char_valid and char_code
//   (char_code is zero when char_valid is low).
//   A request passes through the keymap RAM read register, then the output
//   register, on its way to rsp_valid.
//   Throughput is one word per cycle while rsp_ready stays high; the keymap RAM read
//   port takes one key each cycle and the modifier flags update at acceptance.
//   After reset a sweep loads all 128 keymap RAM rows, one row per
//   cycle; req_ready stays low until it completes. Reset clears shift, ctrl and
//   meta and empties the pipeline.
//   When the receiver stalls, the output word holds and the RAM stage holds one
//   more word; req_ready drops once both are occupied.
`default_nettype none
module scancode_to_ascii_translator_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire logic [scat_pkg::SCAN_WIDTH-1:0] req_scan_code,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      logic                            rsp_char_valid,
   output      logic [scat_pkg::CHAR_WIDTH-1:0] rsp_char_code
);
   import scat_pkg::*;

   fill_port_type         fill;
   logic [KEY_WIDTH-1:0]  key;
   logic                  release_key;
   key_kind_type          kind;
   logic                  accept;
   logic                  advance;
   logic [ROW_WIDTH-1:0]  row;
   logic                  char_valid;
   logic [CHAR_WIDTH-1:0] char_code;

   logic                  shift_ff, shift_in;
   logic                  ctrl_ff, ctrl_in;
   logic                  meta_ff, meta_in;
   logic                  stage_valid_ff, stage_valid_in;
   stage_info_type        stage_info_ff, stage_info_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_char_valid_ff, out_char_valid_in;
   logic [CHAR_WIDTH-1:0] out_char_code_ff, out_char_code_in;

   scat_fill u_fill (
      .clock (clock),
      .reset (reset),
      .fill  (fill)
   );

   scat_ram #(
      .DATA_WIDTH (ROW_WIDTH),
      .DEPTH      (KEYMAP_DEPTH)
   ) u_keymap (
      .clock   (clock),
      .wr_en   (fill.wr_en),
      .wr_addr (fill.wr_addr),
      .wr_data (fill.wr_data),
      .rd_en   (accept),
      .rd_addr (key),
      .rd_data (row)
   );

   scat_format u_format (
      .row        (row),
      .info       (stage_info_ff),
      .char_valid (char_valid),
      .char_code  (char_code)
   );

   always_comb begin
      key         = req_scan_code[KEY_WIDTH-1:0];
      release_key = req_scan_code[SCAN_WIDTH-1];
      kind        = key_kind(key);

      advance   = stage_valid_ff && (!out_valid_ff || rsp_ready);
      req_ready = fill.done && (!stage_valid_ff || advance);
      accept    = req_valid && req_ready;

      // apply modifier press or release
      shift_in = shift_ff;
      ctrl_in  = ctrl_ff;
      meta_in  = meta_ff;
      if (accept) begin
         case (kind)
            KIND_SHIFT: shift_in = !release_key;
            KIND_CTRL:  ctrl_in  = !release_key;
            KIND_META:  meta_in  = !release_key;
            default:    ;
         endcase
      end

      stage_valid_in = accept || (stage_valid_ff && !advance);
      stage_info_in  = stage_info_ff;
      if (accept) begin
         stage_info_in.release_key = release_key;
         stage_info_in.kind        = kind;
         stage_info_in.shift_held  = shift_ff;
         stage_info_in.ctrl_held   = ctrl_ff;
         stage_info_in.meta_held   = meta_ff;
      end

      out_valid_in      = advance || (out_valid_ff && !rsp_ready);
      out_char_valid_in = out_char_valid_ff;
      out_char_code_in  = out_char_code_ff;
      if (advance) begin
         out_char_valid_in = char_valid;
         out_char_code_in  = char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff       <= 1'b0;
         ctrl_ff        <= 1'b0;
         meta_ff        <= 1'b0;
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         shift_ff       <= shift_in;
         ctrl_ff        <= ctrl_in;
         meta_ff        <= meta_in;
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_info_ff     <= stage_info_in;
      out_char_valid_ff <= out_char_valid_in;
      out_char_code_ff  <= out_char_code_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_char_valid = out_char_valid_ff;
   assign rsp_char_code  = out_char_code_ff;

endmodule
`default_nettype wire
